>>> rtl/jakf_pkg.sv
// ----------------------------------------------------------------------------
// jakf_pkg
// Shared types and constants for the joint angle Kalman smoother: field
// widths, configuration register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package jakf_pkg;

    // Number of angle fields carried in every item.
    localparam int FIELDS    = 7;
    localparam int ANGLE_W   = 20;
    localparam int VAR_W     = 27;
    localparam int GAIN_W    = 16;
    localparam int QUO_W     = GAIN_W + 1;
    localparam int CFG_IDX_W = 2;

    // Stream payload: seven angles packed from the lowest bit, padded to bytes.
    localparam int DATA_W = ((FIELDS * ANGLE_W + 7) / 8) * 8;

    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_COV  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd2;

    // Register reset values.
    localparam logic [VAR_W-1:0] START_COV_RST  = 27'd65536000;
    localparam logic [VAR_W-1:0] PROC_NOISE_RST = 27'd655;
    localparam logic [VAR_W-1:0] MEAS_NOISE_RST = 27'd32768;

    typedef logic signed [ANGLE_W-1:0] angle_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_DIV,
        ST_GAIN,
        ST_JOINT,
        ST_VAR,
        ST_OUT
    } jakf_state_t;

endpackage

>>> rtl/joint_angle_kalman_filter.sv
// ----------------------------------------------------------------------------
// joint_angle_kalman_filter
// A load item (or the first item after reset) goes straight from idle to the
// output state. A measurement item passes through the predict step, the 17-step
// restoring divider for the gain, one update per filtered joint (JOINTS capped at
// seven) and the variance update; the joint and variance updates share a single
// multiplier. The input is not ready for a new item until the result is
// registered. Reset (aresetn, synchronous, active low) clears the estimates and
// variance and marks the filter unstarted.
// ----------------------------------------------------------------------------
module joint_angle_kalman_filter
    import jakf_pkg::*;
#(
    parameter int JOINTS = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Input items.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // angle_a, angle_b, ... angle_g, zero pad
    input  logic [0:0]           s_tuser,   // req_type

    // Result items.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // smooth_a, smooth_b, ... smooth_g, zero pad
    output logic [0:0]           m_tuser,   // passed_raw

    // Configuration writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAR_W-1:0]     cfg_data
);

    // Joints that are actually filtered; the rest pass their input.
    localparam int ACTIVE = (JOINTS > FIELDS) ? FIELDS : JOINTS;
    localparam int JIDX_W = 3;
    localparam int CNT_W  = 5;

    jakf_state_t           state_reg, state_next;
    logic                  started_reg, started_next;
    logic                  pass_reg, pass_next;
    angle_t                est_reg  [FIELDS];
    angle_t                est_next [FIELDS];
    angle_t                work_reg  [FIELDS];
    angle_t                work_next [FIELDS];
    logic [VAR_W-1:0]      var_reg, var_next;
    logic [VAR_W-1:0]      p_reg, p_next;
    logic [VAR_W:0]        s_reg, s_next;
    logic [VAR_W+1:0]      rem_reg, rem_next;
    logic [QUO_W-1:0]      q_reg, q_next;
    logic [GAIN_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [JIDX_W-1:0]     jidx_reg, jidx_next;
    logic [VAR_W-1:0]      start_cov_reg, start_cov_next;
    logic [VAR_W-1:0]      proc_noise_reg, proc_noise_next;
    logic [VAR_W-1:0]      meas_noise_reg, meas_noise_next;
    logic                  m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]     m_data_reg, m_data_next;
    logic                  m_user_reg, m_user_next;

    // Datapath intermediates.
    logic [VAR_W:0]        psum;
    logic [VAR_W-1:0]      p_pred;
    logic [VAR_W+1:0]      rem_diff;
    logic                  rem_ge;
    logic [VAR_W+1:0]      rem_keep;
    logic [QUO_W-1:0]      one_minus_k;
    logic signed [ANGLE_W:0]          diff;
    logic signed [QUO_W:0]            mul_a;
    logic signed [VAR_W:0]            mul_b;
    logic signed [QUO_W+VAR_W+1:0]    prod;
    logic signed [QUO_W+VAR_W+1:0]    rnd;
    logic signed [30:0]               xsum;
    angle_t                           xnew;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // Shared datapath: predict add, divider step, and one multiplier.
    always_comb begin
        psum        = {1'b0, var_reg} + {1'b0, proc_noise_reg};
        p_pred      = psum[VAR_W] ? {VAR_W{1'b1}} : psum[VAR_W-1:0];
        rem_diff    = rem_reg - {1'b0, s_reg};
        rem_ge      = (rem_reg >= {1'b0, s_reg});
        rem_keep    = rem_ge ? rem_diff : rem_reg;
        one_minus_k = 17'h10000 - {1'b0, k_reg};
        diff        = {work_reg[jidx_reg][ANGLE_W-1], work_reg[jidx_reg]}
                    - {est_reg[jidx_reg][ANGLE_W-1], est_reg[jidx_reg]};

        // The joint update multiplies gain by difference; the variance update
        // multiplies the predicted variance by one minus the gain.
        if (state_reg == ST_JOINT) begin
            mul_a = {2'b00, k_reg};
            mul_b = {{(VAR_W+1-ANGLE_W-1){diff[ANGLE_W]}}, diff};
        end else begin
            mul_a = {1'b0, one_minus_k};
            mul_b = {1'b0, p_reg};
        end
        prod = mul_a * mul_b;
        rnd  = prod + 46'sd32768;

        // New estimate, saturated to the angle range.
        xsum = {{11{est_reg[jidx_reg][ANGLE_W-1]}}, est_reg[jidx_reg]}
             + {rnd[QUO_W+VAR_W+1], rnd[QUO_W+VAR_W+1:16]};
        if (xsum > 31'sd524287) begin
            xnew = ANGLE_MAX;
        end else if (xsum < -31'sd524288) begin
            xnew = ANGLE_MIN;
        end else begin
            xnew = xsum[ANGLE_W-1:0];
        end
    end

    // Sequencer and next-state values.
    always_comb begin
        state_next      = state_reg;
        started_next    = started_reg;
        pass_next       = pass_reg;
        est_next        = est_reg;
        work_next       = work_reg;
        var_next        = var_reg;
        p_next          = p_reg;
        s_next          = s_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        jidx_next       = jidx_reg;
        start_cov_next  = start_cov_reg;
        proc_noise_next = proc_noise_reg;
        meas_noise_next = meas_noise_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    for (int i = 0; i < FIELDS; i++) begin
                        work_next[i] = s_tdata[i*ANGLE_W +: ANGLE_W];
                    end
                    if (s_tuser[0] || !started_reg) begin
                        // Load: take the input as the estimate and pass it on.
                        for (int i = 0; i < ACTIVE; i++) begin
                            est_next[i] = s_tdata[i*ANGLE_W +: ANGLE_W];
                        end
                        var_next     = start_cov_reg;
                        started_next = 1'b1;
                        pass_next    = 1'b1;
                        state_next   = ST_OUT;
                    end else begin
                        pass_next  = 1'b0;
                        state_next = ST_PRED;
                    end
                end
            end
            ST_PRED: begin
                p_next     = p_pred;
                s_next     = {1'b0, p_pred} + {1'b0, meas_noise_reg};
                rem_next   = {2'b00, p_pred};
                q_next     = '0;
                cnt_next   = CNT_W'(QUO_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // One quotient bit per cycle, most significant first.
                q_next   = {q_reg[QUO_W-2:0], rem_ge};
                rem_next = {rem_keep[VAR_W:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                // Zero total variance gives no correction; full gain clamps.
                if (s_reg == '0) begin
                    k_next = '0;
                end else if (q_reg[QUO_W-1]) begin
                    k_next = {GAIN_W{1'b1}};
                end else begin
                    k_next = q_reg[GAIN_W-1:0];
                end
                jidx_next  = '0;
                state_next = ST_JOINT;
            end
            ST_JOINT: begin
                est_next[jidx_reg]  = xnew;
                work_next[jidx_reg] = xnew;
                if (jidx_reg == JIDX_W'(ACTIVE - 1)) begin
                    state_next = ST_VAR;
                end else begin
                    jidx_next = jidx_reg + 1'b1;
                end
            end
            ST_VAR: begin
                var_next   = rnd[VAR_W+15:16];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    for (int i = 0; i < FIELDS; i++) begin
                        m_data_next[i*ANGLE_W +: ANGLE_W] = work_reg[i];
                    end
                    m_user_next = pass_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Configuration writes; unknown indexes are ignored.
        if (cfg_valid) begin
            case (cfg_index)
                CFG_START_COV:  start_cov_next  = cfg_data;
                CFG_PROC_NOISE: proc_noise_next = cfg_data;
                CFG_MEAS_NOISE: meas_noise_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control state and filter state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            started_reg    <= 1'b0;
            var_reg        <= '0;
            m_valid_reg    <= 1'b0;
            start_cov_reg  <= START_COV_RST;
            proc_noise_reg <= PROC_NOISE_RST;
            meas_noise_reg <= MEAS_NOISE_RST;
            for (int i = 0; i < FIELDS; i++) begin
                est_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            started_reg    <= started_next;
            var_reg        <= var_next;
            m_valid_reg    <= m_valid_next;
            start_cov_reg  <= start_cov_next;
            proc_noise_reg <= proc_noise_next;
            meas_noise_reg <= meas_noise_next;
            est_reg        <= est_next;
        end
    end

    // Working registers without reset.
    always_ff @(posedge aclk) begin
        pass_reg   <= pass_next;
        work_reg   <= work_next;
        p_reg      <= p_next;
        s_reg      <= s_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        k_reg      <= k_next;
        cnt_reg    <= cnt_next;
        jidx_reg   <= jidx_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule

>>> dv/joint_angle_kalman_filter_tb.sv
// ----------------------------------------------------------------------------
// joint_angle_kalman_filter_tb
// Self-checking testbench for the seven-joint angle smoother. An item-level
// predictor keeps its own estimates, shared variance and noise settings and
// computes the expected smoothed vector for every accepted item. A checker
// compares each result item field by field with the oldest expectation.
// Directed tests cover the start-up pass-through, repeated loads, angle
// extremes, zero variance, zero measurement noise and variance saturation.
// Random tracking phases follow under several noise settings, with random
// idling on both stream sides.
// ----------------------------------------------------------------------------
module joint_angle_kalman_filter_tb
    import jakf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int JOINT_COUNT = 7;
    localparam int IDLE_PCT = 19;
    localparam int TRACK_PHASES = 10;
    localparam int TRACK_ITEMS = 55;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [VAR_W-1:0] VAR_MAX = '1;
    localparam longint Q_ONE = 65536;
    localparam longint Q_HALF = 32768;
    localparam longint GAIN_MAX = 65535;

    typedef struct packed {
        logic load;
        angle_t [FIELDS-1:0] angle;
    } joint_req_t;

    typedef struct packed {
        logic passed_raw;
        angle_t [FIELDS-1:0] smooth;
    } joint_est_t;

    typedef enum int {
        NM_DEFAULT,
        NM_MAX,
        NM_MIN,
        NM_RANDOM,
        NM_TYPICAL
    } noise_mode_t;

    string SMOOTH_NAMES [FIELDS] = '{"smooth_a", "smooth_b", "smooth_c", "smooth_d",
                                     "smooth_e", "smooth_f", "smooth_g"};

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic [0:0]        s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [0:0]        m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VAR_W-1:0]  cfg_data = '0;

    // Predictor state and its copy of the noise registers.
    angle_t            est_angle [FIELDS];
    logic [VAR_W-1:0]  est_var = '0;
    logic              filter_started = 1'b0;
    logic [VAR_W-1:0]  cov_start = START_COV_RST;
    logic [VAR_W-1:0]  q_noise = PROC_NOISE_RST;
    logic [VAR_W-1:0]  r_noise = MEAS_NOISE_RST;

    joint_est_t        expected_smooth [$];
    int                fail_count = 0;
    bit                steady_flow = 1'b0;

    joint_angle_kalman_filter #(
        .JOINTS(JOINT_COUNT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    // The result side stalls at random except during the steady stretch.
    always @(negedge aclk) begin
        m_tready = steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic angle_t clip_angle(input longint v);
        if (v > longint'(ANGLE_MAX)) return ANGLE_MAX;
        if (v < longint'(ANGLE_MIN)) return ANGLE_MIN;
        return angle_t'(v);
    endfunction

    // One filter step: load/start-up pass-through or a scalar Kalman update
    // per joint with a shared gain, then the variance shrink.
    function automatic joint_est_t kalman_update(input joint_req_t req);
        joint_est_t res;
        longint p, s, k, d, prod, corr;
        res.smooth = req.angle;
        res.passed_raw = req.load || !filter_started;
        if (res.passed_raw) begin
            for (int i = 0; i < JOINT_COUNT; i++) est_angle[i] = req.angle[i];
            est_var = cov_start;
            filter_started = 1'b1;
        end else begin
            p = longint'(est_var) + longint'(q_noise);
            if (p > longint'(VAR_MAX)) p = longint'(VAR_MAX);
            s = p + longint'(r_noise);
            k = (s == 0) ? 0 : (p * Q_ONE) / s;
            if (k > GAIN_MAX) k = GAIN_MAX;
            for (int i = 0; i < JOINT_COUNT; i++) begin
                d = longint'($signed(req.angle[i])) - longint'(est_angle[i]);
                prod = k * d + Q_HALF;
                // Arithmetic shift floors, giving round half toward +infinity.
                corr = prod >>> 16;
                est_angle[i] = clip_angle(longint'(est_angle[i]) + corr);
                res.smooth[i] = est_angle[i];
            end
            est_var = VAR_W'((p * (Q_ONE - k) + Q_HALF) >> 16);
        end
        return res;
    endfunction

    // Compare every result item with the oldest expectation.
    always @(posedge aclk) begin : check_results
        joint_est_t want;
        joint_est_t got;
        bit bad;
        if (aresetn && m_tvalid && m_tready) begin
            got.passed_raw = m_tuser[0];
            got.smooth = m_tdata[FIELDS*ANGLE_W-1:0];
            if (expected_smooth.size() == 0) begin
                $error("result item with no expectation waiting");
                fail_count++;
            end else begin
                want = expected_smooth.pop_front();
                bad = 1'b0;
                for (int i = 0; i < FIELDS; i++) begin
                    if (got.smooth[i] !== want.smooth[i]) begin
                        bad = 1'b1;
                        $error("%s expected %0d actual %0d", SMOOTH_NAMES[i],
                               $signed(want.smooth[i]), $signed(got.smooth[i]));
                    end
                end
                if (got.passed_raw !== want.passed_raw) begin
                    bad = 1'b1;
                    $error("passed_raw expected %0d actual %0d",
                           want.passed_raw, got.passed_raw);
                end
                if (bad) fail_count++;
            end
        end
    end

    // Send one item; returns at the falling edge after it was accepted,
    // with tvalid still high so that a following item goes out back to back.
    task automatic send_request(input joint_req_t req);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = req.load;
        s_tdata = DATA_W'(req.angle);
        do @(posedge aclk); while (!s_tready);
        expected_smooth.insert(expected_smooth.size(), kalman_update(req));
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_tvalid = 1'b0;
        while (expected_smooth.size() != 0) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [VAR_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_START_COV:  cov_start = val;
            CFG_PROC_NOISE: q_noise = val;
            CFG_MEAS_NOISE: r_noise = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Registers change only once the block has delivered every result.
    task automatic set_noise_model(input logic [VAR_W-1:0] cov, input logic [VAR_W-1:0] q,
                                   input logic [VAR_W-1:0] r);
        wait_results_drained();
        write_register(CFG_START_COV, cov);
        write_register(CFG_PROC_NOISE, q);
        write_register(CFG_MEAS_NOISE, r);
        cfg_valid = 1'b0;
    endtask

    function automatic joint_req_t uniform_req(input logic load, input angle_t value);
        joint_req_t req;
        req.load = load;
        for (int i = 0; i < FIELDS; i++) req.angle[i] = value;
        return req;
    endfunction

    function automatic joint_req_t random_req(input logic load);
        joint_req_t req;
        req.load = load;
        for (int i = 0; i < FIELDS; i++) req.angle[i] = angle_t'($urandom);
        return req;
    endfunction

    // A measurement before any load passes through; then full-scale steps.
    task automatic test_first_measurement();
        joint_req_t req;
        send_request(uniform_req(1'b0, ANGLE_MAX));
        send_request(uniform_req(1'b0, ANGLE_MIN));
        send_request(uniform_req(1'b0, ANGLE_MAX));
        req.load = 1'b0;
        for (int i = 0; i < FIELDS; i++) req.angle[i] = (i % 2) ? ANGLE_MIN : ANGLE_MAX;
        send_request(req);
        send_request(uniform_req(1'b0, '0));
    endtask

    // Every load reloads estimates and variance.
    task automatic test_repeated_load();
        send_request(random_req(1'b1));
        send_request(random_req(1'b1));
        send_request(random_req(1'b0));
    endtask

    // With no variance at all the gain is zero and estimates hold.
    task automatic test_zero_variance();
        set_noise_model('0, '0, '0);
        send_request(uniform_req(1'b1, angle_t'(1000)));
        send_request(uniform_req(1'b0, ANGLE_MAX));
        send_request(uniform_req(1'b0, ANGLE_MIN));
    endtask

    // Zero measurement noise pushes the gain to its clamp.
    task automatic test_zero_measure_noise();
        set_noise_model(VAR_W'(Q_ONE), '0, '0);
        send_request(uniform_req(1'b1, ANGLE_MIN));
        send_request(uniform_req(1'b0, ANGLE_MAX));
        send_request(uniform_req(1'b0, '0));
    endtask

    // Full-scale variance plus full-scale process noise saturates the sum.
    task automatic test_variance_saturation();
        set_noise_model(VAR_MAX, VAR_MAX, VAR_MAX);
        send_request(uniform_req(1'b1, '0));
        send_request(uniform_req(1'b0, ANGLE_MAX));
        send_request(uniform_req(1'b0, ANGLE_MIN));
        send_request(uniform_req(1'b0, ANGLE_MAX));
    endtask

    // Smallest nonzero noise with no start variance.
    task automatic test_min_noise();
        set_noise_model('0, VAR_W'(1), VAR_W'(1));
        send_request(random_req(1'b1));
        send_request(random_req(1'b0));
        send_request(random_req(1'b0));
    endtask

    // Random phases: mostly a load followed by noisy measurements of a
    // slowly drifting pose, with some full-range and stray load items.
    task automatic test_random_tracking();
        noise_mode_t mode;
        angle_t [FIELDS-1:0] base;
        joint_req_t req;
        int roll;
        int offset;
        for (int phase = 0; phase < TRACK_PHASES; phase++) begin
            mode = (phase < 5) ? noise_mode_t'(phase) : noise_mode_t'($urandom_range(4));
            case (mode)
                NM_DEFAULT: set_noise_model(START_COV_RST, PROC_NOISE_RST, MEAS_NOISE_RST);
                NM_MAX:     set_noise_model(VAR_MAX, VAR_MAX, VAR_MAX);
                NM_MIN:     set_noise_model('0, '0, VAR_W'(1));
                NM_RANDOM:  set_noise_model(VAR_W'($urandom), VAR_W'($urandom),
                                            VAR_W'($urandom));
                default:    set_noise_model(VAR_W'($urandom_range(1 << 24)),
                                            VAR_W'($urandom_range(4000)),
                                            VAR_W'($urandom_range(1 << 22, 256)));
            endcase
            // One phase runs with neither side idling.
            steady_flow = (phase == 7);
            for (int i = 0; i < FIELDS; i++) base[i] = angle_t'($urandom);
            for (int n = 0; n < TRACK_ITEMS; n++) begin
                roll = $urandom_range(99);
                if ((roll >= 5 && roll < 15) || (n == 0 && roll >= 85)) begin
                    req = random_req(1'($urandom_range(1)));
                end else begin
                    req.load = (n == 0) || (roll < 5);
                    for (int i = 0; i < FIELDS; i++) begin
                        offset = ($urandom_range(4) == 0)
                                 ? int'($urandom_range(131072)) - 65536
                                 : int'($urandom_range(4096)) - 2048;
                        req.angle[i] = clip_angle(longint'($signed(base[i])) + offset);
                        base[i] = clip_angle(longint'($signed(base[i]))
                                             + int'($urandom_range(600)) - 300);
                    end
                end
                send_request(req);
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < FIELDS; i++) est_angle[i] = '0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        test_first_measurement();
        test_repeated_load();
        test_zero_variance();
        test_zero_measure_noise();
        test_variance_saturation();
        test_min_noise();
        test_random_tracking();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
